FILE: rtl/ssc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int MIN_LEN_W       = 16;
  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 16'd1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [1:0] {
    CLS_BELOW  = 2'd0,
    CLS_INSIDE = 2'd1,
    CLS_ABOVE  = 2'd2
  } cls_t;

  // per-item control that rides alongside the arithmetic
  typedef struct packed {
    logic       empty;
    logic       whole;
    logic       move_s;
    logic       move_e;
    logic [1:0] axis;
  } ctl_t;

endpackage

`default_nettype wire

FILE: rtl/segment_slab_clipper_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+----------------------------------------
// s_axis    | in        | s_tvalid/s_tready  | tuser: req_type; tdata: segment, slab
// m_axis    | out       | m_tvalid/m_tready  | tuser: nonempty; tdata: clipped segment
// cfg       | in        | cfg_valid/cfg_ready| cfg_data: min_length
//
// one item enters per cycle unless a stall on m_tready holds the pipeline; its depth is set by the
// restoring divider, which retires one quotient bit per stage
// rst is synchronous and clears all valid bits; min_length returns to 1
// a stall on m_tready freezes every stage together, so nothing is lost or repeated

module segment_slab_clipper_top #(
  parameter int COORD_WIDTH = ssc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, slab_low, slab_high
  input  wire logic [8*COORD_WIDTH-1:0] s_tdata,
  // req_type
  input  wire logic [1:0]               s_tuser,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // clip_start_x, clip_start_y, clip_start_z, clip_end_x, clip_end_y, clip_end_z, zero fill
  output logic [((6*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // nonempty
  output logic [0:0]                    m_tuser,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [ssc_pkg::MIN_LEN_W-1:0] cfg_data
);

  localparam int W  = COORD_WIDTH;
  localparam int MW = ssc_pkg::MIN_LEN_W;
  localparam int CW = $bits(ssc_pkg::ctl_t);
  localparam int SB = CW + 6*W + 4;
  localparam int OUT_W = ((6*W+7)/8)*8;

  // whole pipeline advances together
  logic en;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // minimum length register and its square
  logic [MW-1:0]   min_len;
  logic [2*MW-1:0] lim;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= ssc_pkg::MIN_LEN_RESET;
    end else if (cfg_valid) begin
      min_len <= cfg_data;
    end
    lim <= (2*MW)'(min_len) * (2*MW)'(min_len);
  end

  // operand preparation and products
  logic          f_valid;
  ssc_pkg::ctl_t f_ctl;
  logic [W-1:0]  f_as, f_ae, f_o1s, f_o1e, f_o2s, f_o2e, f_d;
  logic [3:0]    f_neg;
  logic [8*W-1:0] f_prod;

  ssc_front #(.W(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .req_type  (s_tuser),
    .start_x   (s_tdata[0*W +: W]),
    .start_y   (s_tdata[1*W +: W]),
    .start_z   (s_tdata[2*W +: W]),
    .end_x     (s_tdata[3*W +: W]),
    .end_y     (s_tdata[4*W +: W]),
    .end_z     (s_tdata[5*W +: W]),
    .slab_low  (s_tdata[6*W +: W]),
    .slab_high (s_tdata[7*W +: W]),
    .out_valid (f_valid),
    .out_ctl   (f_ctl),
    .out_as    (f_as),
    .out_ae    (f_ae),
    .out_o1s   (f_o1s),
    .out_o1e   (f_o1e),
    .out_o2s   (f_o2s),
    .out_o2e   (f_o2e),
    .out_neg   (f_neg),
    .out_d     (f_d),
    .out_prod  (f_prod)
  );

  // four divider lanes share the divisor
  logic [4*W-1:0] quot;
  for (genvar j = 0; j < 4; j++) begin : g_lane
    ssc_div_lane #(.W(W)) u_lane (
      .clk  (clk),
      .en   (en),
      .prod (f_prod[j*2*W +: 2*W]),
      .dvsr (f_d),
      .quot (quot[j*W +: W])
    );
  end

  // side data delayed to match the divider depth
  logic [SB-1:0] side [W];
  logic          vld  [W];
  for (genvar k = 0; k < W; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= (k == 0) ? f_valid : vld[(k == 0) ? 0 : k-1];
      end
      if (en) begin
        side[k] <= (k == 0) ? {f_ctl, f_as, f_ae, f_o1s, f_o1e, f_o2s, f_o2e, f_neg}
                            : side[(k == 0) ? 0 : k-1];
      end
    end
  end

  ssc_pkg::ctl_t d_ctl;
  logic [W-1:0]  d_as, d_ae, d_o1s, d_o1e, d_o2s, d_o2e;
  logic [3:0]    d_neg;
  assign {d_ctl, d_as, d_ae, d_o1s, d_o1e, d_o2s, d_o2e, d_neg} = side[W-1];

  logic [6*W-1:0] coords;
  logic           nonempty;

  ssc_back #(.W(W)) u_back (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (vld[W-1]),
    .in_ctl       (d_ctl),
    .in_as        (d_as),
    .in_ae        (d_ae),
    .in_o1s       (d_o1s),
    .in_o1e       (d_o1e),
    .in_o2s       (d_o2s),
    .in_o2e       (d_o2e),
    .in_neg       (d_neg),
    .in_quot      (quot),
    .lim          (lim),
    .out_valid    (m_tvalid),
    .out_nonempty (nonempty),
    .out_coords   (coords)
  );

  assign m_tdata = OUT_W'(coords);
  assign m_tuser = nonempty;

endmodule

`default_nettype wire

FILE: rtl/ssc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ssc_front #(
  parameter int W = ssc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [1:0]          req_type,
  input  wire logic [W-1:0]        start_x,
  input  wire logic [W-1:0]        start_y,
  input  wire logic [W-1:0]        start_z,
  input  wire logic [W-1:0]        end_x,
  input  wire logic [W-1:0]        end_y,
  input  wire logic [W-1:0]        end_z,
  input  wire logic [W-1:0]        slab_low,
  input  wire logic [W-1:0]        slab_high,
  output logic                     out_valid,
  output ssc_pkg::ctl_t            out_ctl,
  output logic [W-1:0]             out_as,
  output logic [W-1:0]             out_ae,
  output logic [W-1:0]             out_o1s,
  output logic [W-1:0]             out_o1e,
  output logic [W-1:0]             out_o2s,
  output logic [W-1:0]             out_o2e,
  output logic [3:0]               out_neg,
  output logic [W-1:0]             out_d,
  output logic [4*2*W-1:0]         out_prod
);

  // magnitude of b - a, with sign flag in the top bit
  function automatic logic [W:0] absdiff(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] df;
    logic [W:0] mg;
    df = {b[W-1], b} - {a[W-1], a};
    mg = df[W] ? (~df + 1'b1) : df;
    return {df[W], mg[W-1:0]};
  endfunction

  // stage 1: permute to axis order, classify endpoints, pick bounds
  logic [W-1:0] c_as, c_ae, c_o1s, c_o1e, c_o2s, c_o2e;
  ssc_pkg::cls_t cs, ce;
  logic bad;
  ssc_pkg::ctl_t c_ctl;

  always_comb begin
    case (req_type)
      ssc_pkg::AXIS_X: begin
        c_as = start_x; c_ae = end_x;
        c_o1s = start_y; c_o1e = end_y; c_o2s = start_z; c_o2e = end_z;
      end
      ssc_pkg::AXIS_Y: begin
        c_as = start_y; c_ae = end_y;
        c_o1s = start_x; c_o1e = end_x; c_o2s = start_z; c_o2e = end_z;
      end
      default: begin
        c_as = start_z; c_ae = end_z;
        c_o1s = start_x; c_o1e = end_x; c_o2s = start_y; c_o2e = end_y;
      end
    endcase
    bad = (req_type != ssc_pkg::AXIS_X && req_type != ssc_pkg::AXIS_Y &&
           req_type != ssc_pkg::AXIS_Z) || ($signed(slab_high) < $signed(slab_low));
    cs = ($signed(c_as) < $signed(slab_low)) ? ssc_pkg::CLS_BELOW :
         ($signed(c_as) > $signed(slab_high)) ? ssc_pkg::CLS_ABOVE : ssc_pkg::CLS_INSIDE;
    ce = ($signed(c_ae) < $signed(slab_low)) ? ssc_pkg::CLS_BELOW :
         ($signed(c_ae) > $signed(slab_high)) ? ssc_pkg::CLS_ABOVE : ssc_pkg::CLS_INSIDE;
    c_ctl.axis   = req_type;
    c_ctl.whole  = (cs == ce) && (cs == ssc_pkg::CLS_INSIDE);
    c_ctl.empty  = bad || ((cs == ce) && (cs != ssc_pkg::CLS_INSIDE));
    c_ctl.move_s = (cs != ssc_pkg::CLS_INSIDE);
    c_ctl.move_e = (ce != ssc_pkg::CLS_INSIDE);
  end

  logic v1;
  ssc_pkg::ctl_t ctl1;
  logic [W-1:0] as1, ae1, o1s1, o1e1, o2s1, o2e1, sb1, eb1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      ctl1 <= c_ctl;
      as1 <= c_as; ae1 <= c_ae;
      o1s1 <= c_o1s; o1e1 <= c_o1e; o2s1 <= c_o2s; o2e1 <= c_o2e;
      sb1 <= (cs == ssc_pkg::CLS_BELOW) ? slab_low : slab_high;
      eb1 <= (ce == ssc_pkg::CLS_BELOW) ? slab_low : slab_high;
    end
  end

  // stage 2: magnitudes, quotient signs, and moved endpoints set to their slab bounds
  logic [W:0] m_d, m_ns, m_ne, m_od1, m_od2;
  always_comb begin
    m_d   = absdiff(as1, ae1);
    m_ns  = absdiff(as1, sb1);
    m_ne  = absdiff(as1, eb1);
    m_od1 = absdiff(o1s1, o1e1);
    m_od2 = absdiff(o2s1, o2e1);
  end

  logic v2;
  ssc_pkg::ctl_t ctl2;
  logic [W-1:0] as2, ae2, o1s2, o1e2, o2s2, o2e2;
  logic [W-1:0] d2, ns2, ne2, od12, od22;
  logic [3:0] neg2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      ctl2 <= ctl1;
      as2 <= ctl1.move_s ? sb1 : as1;
      ae2 <= ctl1.move_e ? eb1 : ae1;
      o1s2 <= o1s1; o1e2 <= o1e1; o2s2 <= o2s1; o2e2 <= o2e1;
      d2 <= m_d[W-1:0]; ns2 <= m_ns[W-1:0]; ne2 <= m_ne[W-1:0];
      od12 <= m_od1[W-1:0]; od22 <= m_od2[W-1:0];
      neg2[0] <= (m_ns[W] ^ m_od1[W]) ^ m_d[W];
      neg2[1] <= (m_ns[W] ^ m_od2[W]) ^ m_d[W];
      neg2[2] <= (m_ne[W] ^ m_od1[W]) ^ m_d[W];
      neg2[3] <= (m_ne[W] ^ m_od2[W]) ^ m_d[W];
    end
  end

  // stage 3: four products, one per interpolated coordinate
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      out_ctl <= ctl2;
      out_as <= as2; out_ae <= ae2;
      out_o1s <= o1s2; out_o1e <= o1e2; out_o2s <= o2s2; out_o2e <= o2e2;
      out_neg <= neg2;
      out_d <= d2;
      out_prod[0*2*W +: 2*W] <= (2*W)'(ns2) * (2*W)'(od12);
      out_prod[1*2*W +: 2*W] <= (2*W)'(ns2) * (2*W)'(od22);
      out_prod[2*2*W +: 2*W] <= (2*W)'(ne2) * (2*W)'(od12);
      out_prod[3*2*W +: 2*W] <= (2*W)'(ne2) * (2*W)'(od22);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ssc_div_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module ssc_div_lane #(
  parameter int W = ssc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [2*W-1:0] prod,
  input  wire logic [W-1:0]   dvsr,
  output logic [W-1:0]        quot
);

  // one quotient bit per stage; high half of product is below the divisor
  logic [W-1:0] rem_r [W];
  logic [W-1:0] q_r   [W];
  logic [W-1:0] lo_r  [W];
  logic [W-1:0] d_r   [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0] rem_i, q_i, lo_i, d_i;
    logic [W:0]   t, diff;
    if (k == 0) begin : g_first
      assign rem_i = prod[2*W-1:W];
      assign q_i   = '0;
      assign lo_i  = prod[W-1:0];
      assign d_i   = dvsr;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign q_i   = q_r[k-1];
      assign lo_i  = lo_r[k-1];
      assign d_i   = d_r[k-1];
    end
    assign t    = {rem_i, lo_i[W-1]};
    assign diff = t - {1'b0, d_i};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= diff[W] ? t[W-1:0] : diff[W-1:0];
        q_r[k]   <= {q_i[W-2:0], ~diff[W]};
        lo_r[k]  <= {lo_i[W-2:0], 1'b0};
        d_r[k]   <= d_i;
      end
    end
  end

  // round to nearest, ties to even
  logic [W:0] twice;
  logic       up;
  always_comb begin
    twice = {rem_r[W-1], 1'b0};
    up    = (twice > {1'b0, d_r[W-1]}) ||
            ((twice == {1'b0, d_r[W-1]}) && q_r[W-1][0]);
    quot  = q_r[W-1] + {{(W-1){1'b0}}, up};
  end

endmodule

`default_nettype wire

FILE: rtl/ssc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ssc_back #(
  parameter int W = ssc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire ssc_pkg::ctl_t       in_ctl,
  input  wire logic [W-1:0]        in_as,
  input  wire logic [W-1:0]        in_ae,
  input  wire logic [W-1:0]        in_o1s,
  input  wire logic [W-1:0]        in_o1e,
  input  wire logic [W-1:0]        in_o2s,
  input  wire logic [W-1:0]        in_o2e,
  input  wire logic [3:0]          in_neg,
  input  wire logic [4*W-1:0]      in_quot,
  input  wire logic [2*ssc_pkg::MIN_LEN_W-1:0] lim,
  output logic                     out_valid,
  output logic                     out_nonempty,
  output logic [6*W-1:0]           out_coords
);

  localparam int MW = ssc_pkg::MIN_LEN_W;

  function automatic logic [W-1:0] apply(input logic [W-1:0] base, input logic [W-1:0] q,
                                         input logic neg, input logic mv);
    logic [W-1:0] r;
    r = neg ? (base - q) : (base + q);
    return mv ? r : base;
  endfunction

  function automatic logic [W-1:0] amag(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] df;
    df = {b[W-1], b} - {a[W-1], a};
    df = df[W] ? (~df + 1'b1) : df;
    return df[W-1:0];
  endfunction

  // stage r: finish interpolated coordinates
  logic vr;
  ssc_pkg::ctl_t ctlr;
  logic [W-1:0] as_r, ae_r, o1s_r, o1e_r, o2s_r, o2e_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (en) begin
      vr <= in_valid;
    end
    if (en) begin
      ctlr  <= in_ctl;
      as_r  <= in_as;
      ae_r  <= in_ae;
      o1s_r <= apply(in_o1s, in_quot[0*W +: W], in_neg[0], in_ctl.move_s);
      o2s_r <= apply(in_o2s, in_quot[1*W +: W], in_neg[1], in_ctl.move_s);
      // moved end point interpolates from the start, else keeps its own value
      o1e_r <= in_ctl.move_e ? apply(in_o1s, in_quot[2*W +: W], in_neg[2], 1'b1) : in_o1e;
      o2e_r <= in_ctl.move_e ? apply(in_o2s, in_quot[3*W +: W], in_neg[3], 1'b1) : in_o2e;
    end
  end

  // stage l: per-axis squared extents, and a flag for any extent too wide to square
  logic [W-1:0] mg0, mg1, mg2;
  always_comb begin
    mg0 = amag(as_r, ae_r);
    mg1 = amag(o1s_r, o1e_r);
    mg2 = amag(o2s_r, o2e_r);
  end

  logic vl;
  ssc_pkg::ctl_t ctll;
  logic [W-1:0] as_l, ae_l, o1s_l, o1e_l, o2s_l, o2e_l;
  logic [2*MW-1:0] sq0, sq1, sq2;
  logic lng;

  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= 1'b0;
    end else if (en) begin
      vl <= vr;
    end
    if (en) begin
      ctll <= ctlr;
      as_l <= as_r; ae_l <= ae_r;
      o1s_l <= o1s_r; o1e_l <= o1e_r; o2s_l <= o2s_r; o2e_l <= o2e_r;
      sq0 <= (2*MW)'(mg0[MW-1:0]) * (2*MW)'(mg0[MW-1:0]);
      sq1 <= (2*MW)'(mg1[MW-1:0]) * (2*MW)'(mg1[MW-1:0]);
      sq2 <= (2*MW)'(mg2[MW-1:0]) * (2*MW)'(mg2[MW-1:0]);
      lng <= (mg0 > W'((1 << MW) - 1)) || (mg1 > W'((1 << MW) - 1)) ||
             (mg2 > W'((1 << MW) - 1));
    end
  end

  // output stage: length test and return to x/y/z order
  logic [2*MW+1:0] sum;
  logic keep;
  logic [W-1:0] sx, sy, sz, ex, ey, ez;

  always_comb begin
    sum  = {2'b00, sq0} + {2'b00, sq1} + {2'b00, sq2};
    keep = !ctll.empty && (ctll.whole || lng || (sum >= {2'b00, lim}));
    case (ctll.axis)
      ssc_pkg::AXIS_X: begin
        sx = as_l; sy = o1s_l; sz = o2s_l; ex = ae_l; ey = o1e_l; ez = o2e_l;
      end
      ssc_pkg::AXIS_Y: begin
        sx = o1s_l; sy = as_l; sz = o2s_l; ex = o1e_l; ey = ae_l; ez = o2e_l;
      end
      default: begin
        sx = o1s_l; sy = o2s_l; sz = as_l; ex = o1e_l; ey = o2e_l; ez = ae_l;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vl;
    end
    if (en) begin
      out_nonempty <= keep;
      out_coords   <= keep ? {ez, ey, ex, sz, sy, sx} : '0;
    end
  end

endmodule

`default_nettype wire
